// ===== hdl/sha1sh_pkg.sv =====
package sha1sh_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0][31:0] t_chain;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam t_chain H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

// ===== hdl/sha1_stream_hasher_top.sv =====
// Byte-serial SHA-1 hasher.
// The input channel (i_valid, o_stall, i_data) carries one transaction per item: an
// absorb item adds i_data.data_byte to the message, a finish item closes the message.
// The output channel (o_valid, i_stall, o_data) returns the 160-bit digest after a
// finish as five transactions, most significant word first, the fifth with last_word.
// An absorb item is taken while the hasher is idle. The 64th byte of a block
// starts the compression, which runs one round per cycle through a single shared
// round unit: 80 rounds, then the chaining add, with o_stall high throughout.
// A finish item pushes the padding and the length one byte per cycle through the same
// block register (a second block follows when the 0x80 byte lands past byte 55), with
// a compression after each full block, then presents the five digest words, one per
// cycle when i_stall stays low.
// While the digest is held, i_stall freezes the current word and no new input is
// taken. After the fifth word the hasher returns to its initial state.
// Reset loads the standard initial chaining values and clears the byte count.
module sha1_stream_hasher_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sha1sh_pkg::t_in_item  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sha1sh_pkg::t_out_item o_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                 r_state;
    sha1sh_pkg::t_chain     r_h;
    logic [63:0]            r_len;
    logic [5:0]             r_fill;
    logic                   r_fin;
    logic                   r_first;
    logic                   r_lenph;
    logic [6:0]             r_rnd;
    logic [2:0]             r_oidx;
    logic [511:0]           r_win;
    sha1sh_pkg::t_word      r_a, r_b, r_c, r_d, r_e;

    logic                   in_acc;
    logic                   push_en;
    logic                   len_now;
    logic [7:0]             push_byte;
    logic                   blk_full;
    sha1sh_pkg::t_word      w_cur, w_new, w_mix, f_val, k_val, t_val;
    logic [2:0]             len_idx;

    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign push_en  = (in_acc && (i_data.func == sha1sh_pkg::FUNC_ABSORB))
                      || (r_state == S_PAD);
    assign blk_full = push_en && (r_fill == sha1sh_pkg::LAST_POS);
    assign len_now  = !r_first && (r_lenph || (r_fill == sha1sh_pkg::LEN_POS));
    assign len_idx  = ~r_fill[2:0];

    always_comb begin
        if (r_state != S_PAD) begin
            push_byte = i_data.data_byte;
        end else if (r_first) begin
            push_byte = sha1sh_pkg::PAD_BYTE;
        end else if (len_now) begin
            push_byte = r_len[{len_idx, 3'b000} +: 8];
        end else begin
            push_byte = 8'd0;
        end
    end

    // Round unit: the window holds W[t] to W[t+15], W[t] in the top word.
    assign w_cur = r_win[511:480];
    assign w_mix = r_win[95:64] ^ r_win[255:224] ^ r_win[447:416] ^ r_win[511:480];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1sh_pkg::K_0;
        end else if (r_rnd < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1sh_pkg::K_1;
        end else if (r_rnd < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1sh_pkg::K_2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1sh_pkg::K_3;
        end
    end

    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= sha1sh_pkg::H_INIT;
            r_len   <= 64'd0;
            r_fill  <= 6'd0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_lenph <= 1'b0;
            r_rnd   <= 7'd0;
            r_oidx  <= 3'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_data.func == sha1sh_pkg::FUNC_FINISH) begin
                            r_fin   <= 1'b1;
                            r_first <= 1'b1;
                            r_lenph <= 1'b0;
                            r_state <= S_PAD;
                        end else begin
                            r_len  <= r_len + 64'd8;
                            r_fill <= r_fill + 6'd1;
                            if (blk_full) begin
                                r_rnd   <= 7'd0;
                                r_state <= S_ROUND;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    r_fill  <= r_fill + 6'd1;
                    if (len_now) begin
                        r_lenph <= 1'b1;
                    end
                    if (blk_full) begin
                        r_rnd   <= 7'd0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == sha1sh_pkg::LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_lenph) begin
                        r_oidx  <= 3'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_oidx == sha1sh_pkg::LAST_WORD) begin
                            r_h     <= sha1sh_pkg::H_INIT;
                            r_len   <= 64'd0;
                            r_fill  <= 6'd0;
                            r_fin   <= 1'b0;
                            r_lenph <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_win <= {r_win[503:0], push_byte};
        end else if (r_state == S_ROUND) begin
            r_win <= {r_win[479:0], w_new};
        end
        if (blk_full) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == S_ROUND) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = (r_state == S_OUT);
    assign o_data.digest_word = r_h[r_oidx];
    assign o_data.word_index  = r_oidx;
    assign o_data.last_word   = (r_oidx == sha1sh_pkg::LAST_WORD);

endmodule
